[design/prrt_pkg.sv]
// ----------------------------------------------------------------------------
// prrt_pkg
// Types and constants shared by the pending range request table.
// ----------------------------------------------------------------------------
package prrt_pkg;

   // operation codes
   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_SCAN    = 2'd2;
   localparam logic [1:0] OP_REPLY   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_VERDICT = 2'd0;
   localparam logic [1:0] KIND_FORWARD = 2'd1;
   localparam logic [1:0] KIND_DELIVER = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   // request verdicts
   localparam logic [2:0] VERD_FORWARD  = 3'd0;
   localparam logic [2:0] VERD_ATTACHED = 3'd1;
   localparam logic [2:0] VERD_CYCLE    = 3'd2;
   localparam logic [2:0] VERD_LOOP     = 3'd3;
   localparam logic [2:0] VERD_FULL     = 3'd4;

   // slot status codes
   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_NEW     = 2'd1;
   localparam logic [1:0] SLOT_PENDING = 2'd2;

   localparam logic [7:0] HOP_CAP = 8'd200;
   localparam int         SLOT_W  = 5;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] client_id;
      logic [63:0] request_handle;
      logic [63:0] range_start;
      logic [31:0] range_length;
      logic [7:0]  hop_count;
      logic        same_host;
      logic        new_only;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        verdict;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       out_client;
      logic [63:0]       out_handle;
      logic [63:0]       out_offset;
      logic [31:0]       out_size;
      logic [7:0]        out_hops;
      logic              last;
   } rsp_type;

   // stored range entry, owner kept apart
   typedef struct packed {
      logic [63:0] range_from;
      logic [63:0] range_to;
      logic [63:0] handle;
      logic [7:0]  hops;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_FINISH,
      ST_DONE
   } state_type;

endpackage

[design/prrt_slot_mem.sv]
// ----------------------------------------------------------------------------
// prrt_slot_mem
// Slot payload memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prrt_slot_mem #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5,
   parameter int OWN_W = 16
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  prrt_pkg::entry_type wr_entry,
   input  logic [OWN_W-1:0]    wr_owner,
   input  logic [IDX_W-1:0]    rd_addr,
   output prrt_pkg::entry_type rd_entry,
   output logic [OWN_W-1:0]    rd_owner
);

   prrt_pkg::entry_type ent_mem [DEPTH];
   logic [OWN_W-1:0]    own_mem [DEPTH];
   prrt_pkg::entry_type rd_entry_ff;
   logic [OWN_W-1:0]    rd_owner_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ent_mem[wr_addr] <= wr_entry;
         own_mem[wr_addr] <= wr_owner;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_entry_ff <= ent_mem[rd_addr];
      rd_owner_ff <= own_mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;
   assign rd_owner = rd_owner_ff;

endmodule

[design/pending_range_request_table_core.sv]
// ----------------------------------------------------------------------------
// pending_range_request_table_core
// Table of outstanding byte-range requests: admit, remove, forward scan and
// reply delivery, one slot examined per cycle.
// ----------------------------------------------------------------------------
//  channel | ports                       | direction | handshake
//  request | start, busy, req_payload    | in        | start && !busy
//  result  | rsp_strobe, rsp_payload     | out       | strobe, one cycle
//
//  an operation holds busy from the fetch, through the walk over the used slots
//  of the payload memory, to the final result state
//  busy drops as the last result is shown, so the next transaction can follow
//  reset clears every slot status to free and used_length to zero
//  results cannot be held off; each one is shown for exactly one cycle
// ----------------------------------------------------------------------------
module pending_range_request_table_core #(
   parameter int QUEUE_DEPTH    = 32,
   parameter int CLIENT_ID_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  prrt_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output prrt_pkg::rsp_type rsp_payload
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
   localparam int OWN_W = (CLIENT_ID_BITS < 16) ? CLIENT_ID_BITS : 16;

   prrt_pkg::state_type state_ff, state_in;

   logic [1:0]       status_ff [QUEUE_DEPTH];
   logic [1:0]       status_in [QUEUE_DEPTH];
   logic [LEN_W-1:0] used_ff, used_in;

   logic [1:0]       op_ff, op_in;
   logic [OWN_W-1:0] cid_ff, cid_in;
   logic [63:0]      handle_ff, handle_in;
   logic [63:0]      start_ff, start_in;
   logic [63:0]      end_ff, end_in;
   logic [7:0]       hops_ff, hops_in;
   logic             new_only_ff, new_only_in;
   logic             cycle_ff, cycle_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             found_vld_ff, found_vld_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic             found_pend_ff, found_pend_in;
   logic             free_vld_ff, free_vld_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             loop_ff, loop_in;

   logic              rsp_vld_ff, rsp_vld_in;
   prrt_pkg::rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic                brk;
   logic                ascend;
   logic [IDX_W-1:0]    next_idx;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   prrt_pkg::entry_type wr_entry;
   prrt_pkg::entry_type rd_entry;
   logic [OWN_W-1:0]    rd_owner;
   logic [1:0]          cur_st;
   logic                cur_live;
   logic [7:0]          fwd_hops;
   logic [IDX_W-1:0]    tgt;
   logic                attach;

   assign accept   = start && (state_ff == prrt_pkg::ST_IDLE);
   assign busy     = (state_ff != prrt_pkg::ST_IDLE);
   assign ascend   = (op_ff == prrt_pkg::OP_REQUEST) || (op_ff == prrt_pkg::OP_SCAN);
   assign next_idx = ascend ? (idx_ff + IDX_W'(1)) : (idx_ff - IDX_W'(1));
   assign rd_addr  = (state_ff == prrt_pkg::ST_FETCH) ? idx_ff : next_idx;
   assign cur_st   = status_ff[idx_ff];
   assign cur_live = (cur_st == prrt_pkg::SLOT_NEW) || (cur_st == prrt_pkg::SLOT_PENDING);
   assign fwd_hops = (rd_entry.hops < prrt_pkg::HOP_CAP) ? (rd_entry.hops + 8'd1)
                                                          : rd_entry.hops;
   assign tgt      = free_vld_ff ? free_idx_ff : used_ff[IDX_W-1:0];
   assign attach   = found_vld_ff && !(found_pend_ff && (tgt > found_idx_ff));

   // payload memory
   prrt_slot_mem #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IDX_W),
      .OWN_W (OWN_W)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .wr_owner (cid_ff),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_owner (rd_owner)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prrt_pkg::ST_IDLE: begin
            if (accept) state_in = prrt_pkg::ST_FETCH;
         end
         prrt_pkg::ST_FETCH: begin
            if (cycle_ff) state_in = prrt_pkg::ST_FINISH;
            else if (rem_ff == '0)
               state_in = (op_ff == prrt_pkg::OP_REQUEST) ? prrt_pkg::ST_FINISH
                                                          : prrt_pkg::ST_DONE;
            else state_in = prrt_pkg::ST_EVAL;
         end
         prrt_pkg::ST_EVAL: begin
            if (brk || (rem_ff == LEN_W'(1)))
               state_in = (op_ff == prrt_pkg::OP_REQUEST) ? prrt_pkg::ST_FINISH
                                                          : prrt_pkg::ST_DONE;
         end
         prrt_pkg::ST_FINISH: state_in = prrt_pkg::ST_IDLE;
         prrt_pkg::ST_DONE:   state_in = prrt_pkg::ST_IDLE;
         default:             state_in = prrt_pkg::ST_IDLE;
      endcase
   end

   // datapath and results
   always_comb begin
      status_in     = status_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      cid_in        = cid_ff;
      handle_in     = handle_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      hops_in       = hops_ff;
      new_only_in   = new_only_ff;
      cycle_in      = cycle_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      found_vld_in  = found_vld_ff;
      found_idx_in  = found_idx_ff;
      found_pend_in = found_pend_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      loop_in       = loop_ff;
      rsp_vld_in    = 1'b0;
      rsp_in        = '0;
      brk           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = tgt;
      wr_entry      = '{range_from: start_ff, range_to: end_ff,
                        handle: handle_ff, hops: hops_ff};
      unique case (state_ff)
         prrt_pkg::ST_IDLE: begin
            if (accept) begin
               op_in         = req_payload.opcode;
               cid_in        = req_payload.client_id[OWN_W-1:0];
               handle_in     = req_payload.request_handle;
               start_in      = req_payload.range_start;
               end_in        = req_payload.range_start + 64'(req_payload.range_length);
               hops_in       = req_payload.hop_count;
               new_only_in   = req_payload.new_only;
               cycle_in      = (req_payload.opcode == prrt_pkg::OP_REQUEST) &&
                               req_payload.same_host && (req_payload.hop_count != 8'd0);
               rem_in        = used_ff;
               found_vld_in  = 1'b0;
               found_pend_in = 1'b0;
               free_vld_in   = 1'b0;
               loop_in       = 1'b0;
               if ((req_payload.opcode == prrt_pkg::OP_REQUEST) ||
                   (req_payload.opcode == prrt_pkg::OP_SCAN))
                  idx_in = '0;
               else
                  idx_in = IDX_W'(used_ff - LEN_W'(1));
            end
         end
         prrt_pkg::ST_FETCH: begin
         end
         prrt_pkg::ST_EVAL: begin
            rem_in = rem_ff - LEN_W'(1);
            idx_in = next_idx;
            unique case (op_ff)
               prrt_pkg::OP_REQUEST: begin
                  // first free slot, then covering live entries
                  if (!free_vld_ff && (cur_st == prrt_pkg::SLOT_FREE)) begin
                     free_vld_in = 1'b1;
                     free_idx_in = idx_ff;
                  end else if (cur_live && (rd_entry.range_from <= start_ff) &&
                               (rd_entry.range_to >= end_ff)) begin
                     if (hops_ff > rd_entry.hops) begin
                        loop_in = 1'b1;
                        brk     = 1'b1;
                     end else if (!found_vld_ff || found_pend_ff) begin
                        found_vld_in  = 1'b1;
                        found_idx_in  = idx_ff;
                        found_pend_in = (cur_st == prrt_pkg::SLOT_PENDING);
                        if (free_vld_ff) brk = 1'b1;
                     end
                  end
               end
               prrt_pkg::OP_REMOVE: begin
                  if ((cur_st != prrt_pkg::SLOT_FREE) && (rd_owner == cid_ff))
                     status_in[idx_ff] = prrt_pkg::SLOT_FREE;
                  if (((cur_st == prrt_pkg::SLOT_FREE) || (rd_owner == cid_ff)) &&
                      (used_ff == (LEN_W'(idx_ff) + LEN_W'(1))))
                     used_in = LEN_W'(idx_ff);
               end
               prrt_pkg::OP_SCAN: begin
                  if ((cur_st == prrt_pkg::SLOT_NEW) ||
                      (!new_only_ff && (cur_st == prrt_pkg::SLOT_PENDING))) begin
                     status_in[idx_ff]  = prrt_pkg::SLOT_PENDING;
                     rsp_vld_in         = 1'b1;
                     rsp_in.kind        = prrt_pkg::KIND_FORWARD;
                     rsp_in.slot        = prrt_pkg::SLOT_W'(idx_ff);
                     rsp_in.out_client  = 16'(rd_owner);
                     rsp_in.out_handle  = rd_entry.handle;
                     rsp_in.out_offset  = rd_entry.range_from;
                     rsp_in.out_size    = rd_entry.range_to[31:0] - rd_entry.range_from[31:0];
                     rsp_in.out_hops    = fwd_hops;
                  end
               end
               prrt_pkg::OP_REPLY: begin
                  // covered entries are delivered and freed, top slot first
                  if (cur_live && (rd_entry.range_from >= start_ff) &&
                      (rd_entry.range_to <= end_ff)) begin
                     status_in[idx_ff]  = prrt_pkg::SLOT_FREE;
                     rsp_vld_in         = 1'b1;
                     rsp_in.kind        = prrt_pkg::KIND_DELIVER;
                     rsp_in.slot        = prrt_pkg::SLOT_W'(idx_ff);
                     rsp_in.out_client  = 16'(rd_owner);
                     rsp_in.out_handle  = rd_entry.handle;
                     rsp_in.out_offset  = rd_entry.range_from - start_ff;
                     rsp_in.out_size    = rd_entry.range_to[31:0] - rd_entry.range_from[31:0];
                     if (used_ff == (LEN_W'(idx_ff) + LEN_W'(1)))
                        used_in = LEN_W'(idx_ff);
                  end else if ((cur_st == prrt_pkg::SLOT_FREE) &&
                               (used_ff == (LEN_W'(idx_ff) + LEN_W'(1)))) begin
                     used_in = LEN_W'(idx_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         prrt_pkg::ST_FINISH: begin
            // request verdict and slot write
            rsp_vld_in  = 1'b1;
            rsp_in.kind = prrt_pkg::KIND_VERDICT;
            rsp_in.last = 1'b1;
            priority if (cycle_ff) begin
               rsp_in.verdict = prrt_pkg::VERD_CYCLE;
            end else if (loop_ff) begin
               rsp_in.verdict = prrt_pkg::VERD_LOOP;
            end else if (!free_vld_ff && (used_ff >= LEN_W'(QUEUE_DEPTH))) begin
               rsp_in.verdict = prrt_pkg::VERD_FULL;
            end else begin
               if (!free_vld_ff) used_in = used_ff + LEN_W'(1);
               wr_en          = 1'b1;
               status_in[tgt] = attach ? prrt_pkg::SLOT_PENDING : prrt_pkg::SLOT_NEW;
               rsp_in.verdict = attach ? prrt_pkg::VERD_ATTACHED : prrt_pkg::VERD_FORWARD;
               rsp_in.slot    = prrt_pkg::SLOT_W'(tgt);
            end
         end
         prrt_pkg::ST_DONE: begin
            rsp_vld_in  = 1'b1;
            rsp_in.kind = prrt_pkg::KIND_DONE;
            rsp_in.last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prrt_pkg::ST_IDLE;
         used_ff    <= '0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < QUEUE_DEPTH; i++) status_ff[i] <= prrt_pkg::SLOT_FREE;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         rsp_vld_ff <= rsp_vld_in;
         status_ff  <= status_in;
      end
   end

   // operation context and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cid_ff        <= cid_in;
      handle_ff     <= handle_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      hops_ff       <= hops_in;
      new_only_ff   <= new_only_in;
      cycle_ff      <= cycle_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      found_vld_ff  <= found_vld_in;
      found_idx_ff  <= found_idx_in;
      found_pend_ff <= found_pend_in;
      free_vld_ff   <= free_vld_in;
      free_idx_ff   <= free_idx_in;
      loop_ff       <= loop_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe  = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LEN_W'(QUEUE_DEPTH))
      else $error("used length beyond table depth");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.last |-> state_ff == prrt_pkg::ST_IDLE)
      else $error("final result while still busy");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_strobe)
      else $error("result right after accepting a transaction");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.kind == prrt_pkg::KIND_DONE) |-> rsp_payload.last)
      else $error("done result without last");

endmodule

[dv/pending_range_request_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_range_request_table_checker
// Watches the request and result channels of the range request table, keeps
// its own copy of the slot table, predicts every result and compares.
// ----------------------------------------------------------------------------
module pending_range_request_table_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  prrt_pkg::req_type req_payload,
   input  logic              rsp_strobe,
   input  prrt_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                outstanding
);

   localparam int DEPTH = 32;

   // shadow of the slot table
   logic [1:0]  shadow_status [DEPTH];
   logic [63:0] shadow_from   [DEPTH];
   logic [63:0] shadow_to     [DEPTH];
   logic [63:0] shadow_handle [DEPTH];
   logic [15:0] shadow_owner  [DEPTH];
   logic [7:0]  shadow_hops   [DEPTH];
   int          shadow_used;

   prrt_pkg::rsp_type expected_results[$];

   assign outstanding = expected_results.size();

   function automatic prrt_pkg::rsp_type make_result(logic [1:0] kind, logic [2:0] verdict,
                                                     int slot, logic [15:0] client,
                                                     logic [63:0] handle,
                                                     logic [63:0] offset,
                                                     logic [63:0] size, logic [7:0] hops,
                                                     logic last);
      prrt_pkg::rsp_type r;
      r.kind       = kind;
      r.verdict    = verdict;
      r.slot       = slot[prrt_pkg::SLOT_W-1:0];
      r.out_client = client;
      r.out_handle = handle;
      r.out_offset = offset;
      r.out_size   = size[31:0];
      r.out_hops   = hops;
      r.last       = last;
      return r;
   endfunction

   function automatic bit slot_live(int i);
      return shadow_status[i] == prrt_pkg::SLOT_NEW ||
             shadow_status[i] == prrt_pkg::SLOT_PENDING;
   endfunction

   // apply one accepted transaction to the shadow table and queue its results
   task automatic predict_table_op(prrt_pkg::req_type t);
      logic [63:0] range_end;
      int          found, free_slot, ul, h;
      logic [1:0]  found_type;
      bit          loop_hit;
      bit          hit [DEPTH];
      range_end  = t.range_start + 64'(t.range_length);
      ul         = shadow_used > DEPTH ? DEPTH : shadow_used;
      found      = -1;
      free_slot  = -1;
      found_type = prrt_pkg::SLOT_FREE;
      loop_hit   = 0;
      unique case (t.opcode)
         prrt_pkg::OP_REQUEST: begin
            if (t.hop_count != 0 && t.same_host) begin
               expected_results.push_back(make_result(prrt_pkg::KIND_VERDICT,
                                          prrt_pkg::VERD_CYCLE, 0, 0, 0, 0, 0, 0, 1));
               return;
            end
            for (int i = 0; i < ul; i++) begin
               if (free_slot == -1 && shadow_status[i] == prrt_pkg::SLOT_FREE) begin
                  free_slot = i;
                  continue;
               end
               if (!slot_live(i)) continue;
               if (shadow_from[i] <= t.range_start && shadow_to[i] >= range_end) begin
                  if (t.hop_count > shadow_hops[i]) begin
                     loop_hit = 1;
                     break;
                  end
                  if (found == -1 || found_type == prrt_pkg::SLOT_PENDING) begin
                     found      = i;
                     found_type = shadow_status[i];
                     if (free_slot != -1) break;
                  end
               end
            end
            if (loop_hit) begin
               expected_results.push_back(make_result(prrt_pkg::KIND_VERDICT,
                                          prrt_pkg::VERD_LOOP, 0, 0, 0, 0, 0, 0, 1));
               return;
            end
            if (free_slot == -1) begin
               if (ul >= DEPTH) begin
                  expected_results.push_back(make_result(prrt_pkg::KIND_VERDICT,
                                             prrt_pkg::VERD_FULL, 0, 0, 0, 0, 0, 0, 1));
                  return;
               end
               free_slot   = ul;
               shadow_used = ul + 1;
            end
            if (found != -1 && found_type != prrt_pkg::SLOT_NEW && free_slot > found)
               found = -1;
            shadow_from[free_slot]   = t.range_start;
            shadow_to[free_slot]     = range_end;
            shadow_handle[free_slot] = t.request_handle;
            shadow_owner[free_slot]  = t.client_id;
            shadow_status[free_slot] = found == -1 ? prrt_pkg::SLOT_NEW
                                                   : prrt_pkg::SLOT_PENDING;
            shadow_hops[free_slot]   = t.hop_count;
            expected_results.push_back(make_result(prrt_pkg::KIND_VERDICT,
               found == -1 ? prrt_pkg::VERD_FORWARD : prrt_pkg::VERD_ATTACHED,
               free_slot, 0, 0, 0, 0, 0, 1));
         end
         prrt_pkg::OP_REMOVE: begin
            for (int i = ul - 1; i >= 0; i--) begin
               if (shadow_status[i] != prrt_pkg::SLOT_FREE && shadow_owner[i] == t.client_id)
                  shadow_status[i] = prrt_pkg::SLOT_FREE;
               if (shadow_status[i] == prrt_pkg::SLOT_FREE && shadow_used == i + 1)
                  shadow_used = i;
            end
            expected_results.push_back(make_result(prrt_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0,
                                                   0, 1));
         end
         prrt_pkg::OP_SCAN: begin
            for (int i = 0; i < ul; i++) begin
               if (shadow_status[i] != prrt_pkg::SLOT_NEW &&
                   (t.new_only || shadow_status[i] != prrt_pkg::SLOT_PENDING)) continue;
               shadow_status[i] = prrt_pkg::SLOT_PENDING;
               h = shadow_hops[i];
               if (h < prrt_pkg::HOP_CAP) h++;
               expected_results.push_back(make_result(prrt_pkg::KIND_FORWARD, 0, i,
                  shadow_owner[i], shadow_handle[i], shadow_from[i],
                  shadow_to[i] - shadow_from[i], h[7:0], 0));
            end
            expected_results.push_back(make_result(prrt_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0,
                                                   0, 1));
         end
         prrt_pkg::OP_REPLY: begin
            for (int i = 0; i < DEPTH; i++)
               hit[i] = i < ul && slot_live(i) && shadow_from[i] >= t.range_start &&
                        shadow_to[i] <= range_end;
            for (int i = ul - 1; i >= 0; i--) begin
               if (hit[i]) begin
                  expected_results.push_back(make_result(prrt_pkg::KIND_DELIVER, 0, i,
                     shadow_owner[i], shadow_handle[i], shadow_from[i] - t.range_start,
                     shadow_to[i] - shadow_from[i], 0, 0));
                  shadow_status[i] = prrt_pkg::SLOT_FREE;
               end
               if (shadow_status[i] == prrt_pkg::SLOT_FREE && shadow_used == i + 1)
                  shadow_used = i;
            end
            expected_results.push_back(make_result(prrt_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0,
                                                   0, 1));
         end
      endcase
   endtask

   // field by field comparison against the oldest expectation
   task automatic compare_result(prrt_pkg::rsp_type got);
      prrt_pkg::rsp_type exp_r;
      if (expected_results.size() == 0) begin
         $error("unexpected result transaction: %p", got);
         fail_count++;
         return;
      end
      exp_r = expected_results.pop_front();
      if (got.kind !== exp_r.kind) begin
         $error("kind expected %0d actual %0d", exp_r.kind, got.kind); fail_count++;
      end
      if (got.verdict !== exp_r.verdict) begin
         $error("verdict expected %0d actual %0d", exp_r.verdict, got.verdict); fail_count++;
      end
      if (got.slot !== exp_r.slot) begin
         $error("slot expected %0d actual %0d", exp_r.slot, got.slot); fail_count++;
      end
      if (got.out_client !== exp_r.out_client) begin
         $error("out_client expected %h actual %h", exp_r.out_client, got.out_client);
         fail_count++;
      end
      if (got.out_handle !== exp_r.out_handle) begin
         $error("out_handle expected %h actual %h", exp_r.out_handle, got.out_handle);
         fail_count++;
      end
      if (got.out_offset !== exp_r.out_offset) begin
         $error("out_offset expected %h actual %h", exp_r.out_offset, got.out_offset);
         fail_count++;
      end
      if (got.out_size !== exp_r.out_size) begin
         $error("out_size expected %h actual %h", exp_r.out_size, got.out_size);
         fail_count++;
      end
      if (got.out_hops !== exp_r.out_hops) begin
         $error("out_hops expected %0d actual %0d", exp_r.out_hops, got.out_hops);
         fail_count++;
      end
      if (got.last !== exp_r.last) begin
         $error("last expected %0d actual %0d", exp_r.last, got.last); fail_count++;
      end
   endtask

   initial fail_count = 0;

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) shadow_status[i] = prrt_pkg::SLOT_FREE;
         shadow_used = 0;
         expected_results.delete();
      end else begin
         if (rsp_strobe) compare_result(rsp_payload);
         if (start && !busy) predict_table_op(req_payload);
      end
   end

   final begin
      if (expected_results.size() != 0)
         $error("%0d expected results never arrived", expected_results.size());
   end
endmodule

[dv/pending_range_request_table_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_range_request_table_core_tb
// Drives directed and random table operations into the range request table
// with random idle bursts; a checker beside the block predicts the results.
// ----------------------------------------------------------------------------
module pending_range_request_table_core_tb;

   localparam int RANDOM_OPS  = 372;
   localparam int STALL_LIMIT = 20000;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   prrt_pkg::req_type req_payload = '0;
   logic              rsp_strobe;
   prrt_pkg::rsp_type rsp_payload;
   int                fail_count;
   int                outstanding;
   int                idle_cycles = 0;
   bit                no_idling = 0;
   logic [15:0] client_pool [4] = '{16'h0000, 16'hffff, 16'h1234, 16'h8001};

   always #10 clock = ~clock;

   pending_range_request_table_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   pending_range_request_table_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // watchdog on cycles without any accepted transaction or result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // present one transaction at a falling edge and hold it until accepted
   task automatic issue_op(prrt_pkg::req_type t);
      int gap;
      @(negedge clock);
      if (!no_idling && $urandom_range(0, 3) == 0) begin
         gap   = $urandom_range(1, 18);
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= t;
      start       <= 1;
      do @(posedge clock); while (busy);
   endtask

   // drop start after the last transaction of a stretch
   task automatic release_start();
      @(negedge clock);
      start <= 0;
   endtask

   function automatic prrt_pkg::req_type build_op(logic [1:0] op, logic [15:0] cid,
                                                  logic [63:0] lo, logic [31:0] len,
                                                  logic [7:0] hops, bit same, bit newo);
      prrt_pkg::req_type t;
      t.opcode         = op;
      t.client_id      = cid;
      t.request_handle = {$urandom, $urandom};
      t.range_start    = lo;
      t.range_length   = len;
      t.hop_count      = hops;
      t.same_host      = same;
      t.new_only       = newo;
      return t;
   endfunction

   // mostly overlapping ranges in a small window so attaches and deliveries happen
   function automatic prrt_pkg::req_type random_op();
      logic [1:0]  op;
      logic [63:0] lo;
      logic [31:0] len;
      int          pick;
      pick = $urandom_range(0, 99);
      op   = pick < 55 ? prrt_pkg::OP_REQUEST : pick < 65 ? prrt_pkg::OP_REMOVE :
             pick < 82 ? prrt_pkg::OP_SCAN : prrt_pkg::OP_REPLY;
      if ($urandom_range(0, 9) == 0) begin
         lo  = {$urandom, $urandom};
         len = $urandom;
      end else begin
         lo  = 64'h1000 + $urandom_range(0, 4096);
         len = op == prrt_pkg::OP_REPLY ? $urandom_range(0, 8192) : $urandom_range(0, 1024);
      end
      return build_op(op, client_pool[$urandom_range(0, 3)] ^
                      ($urandom_range(0, 7) == 0 ? 16'($urandom) : 16'h0), lo, len,
                      $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 4)),
                      $urandom_range(0, 4) == 0, $urandom_range(0, 1));
   endfunction

   initial begin
      prrt_pkg::req_type t;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: forward, attach, cycle, loop, zero-hop same host, overflow
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'h0001, 64'h100, 32'h100, 8'd5, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'hffff, 64'h140, 32'h10, 8'd3, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'h0002, 64'h140, 32'h10, 8'd9, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'h0003, 64'h0, 32'h1, 8'd1, 1, 0));
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'h0003, 64'h0, 32'h1, 8'd0, 1, 1));
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'h0004, '1, '1, 8'd255, 0, 1));
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'h0005, 64'h200, 32'h0, 8'd200, 0, 0));
      issue_op(build_op(prrt_pkg::OP_SCAN, 16'h0, 64'h0, 32'h0, 8'd0, 0, 1));
      issue_op(build_op(prrt_pkg::OP_SCAN, 16'h0, 64'h0, 32'h0, 8'd0, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REQUEST, 16'h0006, 64'h150, 32'h8, 8'd2, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REMOVE, 16'hbeef, 64'h0, 32'h0, 8'd0, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REMOVE, 16'h0004, 64'h0, 32'h0, 8'd0, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REPLY, 16'h0, 64'h100, 32'h100, 8'd0, 0, 0));
      issue_op(build_op(prrt_pkg::OP_REPLY, 16'h0, 64'h0, 32'hffffffff, 8'd0, 1, 1));
      // fill the table to full, then reject once
      for (int i = 0; i < 33; i++)
         issue_op(build_op(prrt_pkg::OP_REQUEST, 16'(i), 64'(i) << 12, 32'h80, 8'd255,
                           0, 0));
      // sender waits for all expected results to arrive before freeing everything
      release_start();
      wait (outstanding == 0);
      issue_op(build_op(prrt_pkg::OP_REPLY, 16'h0, 64'h0, 32'hffffffff, 8'd0, 0, 0));

      // random part; idling stops for the last stretch
      for (int n = 0; n < RANDOM_OPS; n++) begin
         no_idling = n >= RANDOM_OPS - 60;
         t = random_op();
         issue_op(t);
      end
      release_start();

      wait (outstanding == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
